FILE: src/sss_pkg.sv
// Package for the seven-segment scan serializer: sizes, register indexes,
// the segment table and the types shared by the lanes, the shifter and the top level.
// Depends on nothing.
package sss_pkg;

   localparam int DIGIT_COUNT = 4;
   localparam int FIELD_DIGITS = 4;
   localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIT_ORDER = 1'b0,
      CSR_DWELL_MS  = 1'b1
   } csr_index_type;

   typedef logic [7:0] seg_byte_type;

   localparam seg_byte_type SEG_DP    = 8'h80;
   localparam seg_byte_type SEG_BLANK = 8'h00;

   typedef struct packed {
      logic busy;
      logic done;
   } ser_status_type;

   function automatic seg_byte_type seg_pattern(input logic [3:0] value);
      seg_byte_type pat;
      case (value)
         4'd0: pat = 8'h3f;
         4'd1: pat = 8'h06;
         4'd2: pat = 8'h5b;
         4'd3: pat = 8'h4f;
         4'd4: pat = 8'h66;
         4'd5: pat = 8'h6d;
         4'd6: pat = 8'h7d;
         4'd7: pat = 8'h07;
         4'd8: pat = 8'h7f;
         4'd9: pat = 8'h6f;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

endpackage

FILE: src/sss_channels.sv
// Handshake channels of the seven-segment scan serializer: the refresh request
// channel and the serial bit channel. Depends on nothing.
interface sss_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] digit_0;
   logic [3:0] digit_1;
   logic [3:0] digit_2;
   logic [3:0] digit_3;
   logic [1:0] dp_position;

   modport source (output valid, digit_0, digit_1, digit_2, digit_3, dp_position,
                   input ready);
   modport sink (input valid, digit_0, digit_1, digit_2, digit_3, dp_position,
                 output ready);
endinterface

interface sss_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] digit_enable_n;
   logic       serial_bit;
   logic       latch_after;
   logic       hold_after;
   logic       last;

   modport source (output valid, digit_enable_n, serial_bit, latch_after, hold_after, last,
                   input ready);
   modport sink (input valid, digit_enable_n, serial_bit, latch_after, hold_after, last,
                 output ready);
endinterface

FILE: src/seven_segment_scan_serializer.sv
// Top level of the seven-segment scan serializer: digit lanes, a one-request buffer,
// the shifter and the configuration register. Depends on sss_pkg, sss_channels,
// sss_lane and sss_serializer.
//
// Each request refreshes a four-digit common-anode display once and yields 64
// serial bits, one per cycle while the consumer is ready: for each digit a pattern
// byte, whose eighth bit carries latch_after and hold_after, then a blank byte, whose
// eighth bit carries latch_after. While a request occupies the shifter, one further
// request is buffered behind it so that refreshes follow without a gap. The bit order
// register is applied as bits leave; the dwell time is marked by hold_after and timed
// by the consumer, so a write to the dwell register changes nothing here.
// Configuration should only be written while the block is idle.
module seven_segment_scan_serializer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [sss_pkg::CSR_IDX_W-1:0]   csr_wr_index,
   input  logic [sss_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   sss_req_if.sink                         req_chan,
   sss_rsp_if.source                       rsp_chan
);

   logic                    bit_order_ff, bit_order_in;
   logic                    pend_valid_ff, pend_valid_in;
   sss_pkg::seg_byte_type   pend_bytes_ff [sss_pkg::DIGIT_COUNT];
   sss_pkg::seg_byte_type   lane_byte [sss_pkg::DIGIT_COUNT];
   logic [3:0]              digit_in [sss_pkg::FIELD_DIGITS];
   sss_pkg::ser_status_type ser_status;
   logic                    load;
   logic                    accept;

   assign digit_in[0] = req_chan.digit_0;
   assign digit_in[1] = req_chan.digit_1;
   assign digit_in[2] = req_chan.digit_2;
   assign digit_in[3] = req_chan.digit_3;

   for (genvar i = 0; i < sss_pkg::DIGIT_COUNT; i++) begin : g_lane
      sss_lane u_lane (
         .digit   (digit_in[i]),
         .dp_here ((req_chan.dp_position == 2'(i)) && (req_chan.dp_position != 2'd3)),
         .pattern (lane_byte[i])
      );
   end

   assign load           = pend_valid_ff && (!ser_status.busy || ser_status.done);
   assign req_chan.ready = !pend_valid_ff || load;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
      end else if (load) begin
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      bit_order_in = bit_order_ff;
      if (csr_wr_en && (csr_wr_index == sss_pkg::CSR_BIT_ORDER)) begin
         bit_order_in = csr_wr_data[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         bit_order_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         bit_order_ff  <= bit_order_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_bytes_ff <= lane_byte;
      end
   end

   sss_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .bit_order  (bit_order_ff),
      .load       (load),
      .load_bytes (pend_bytes_ff),
      .status     (ser_status),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: src/sss_lane.sv
// One digit lane: turns a digit value and its decimal-point flag into a segment byte.
// Depends on sss_pkg.
module sss_lane (
   input  logic [3:0]            digit,
   input  logic                  dp_here,
   output sss_pkg::seg_byte_type pattern
);

   assign pattern = sss_pkg::seg_pattern(digit) | (dp_here ? sss_pkg::SEG_DP : sss_pkg::SEG_BLANK);

endmodule

FILE: src/sss_serializer.sv
// Merging shifter: walks the lane bytes digit by digit, sending each pattern byte
// and then a blank byte one bit at a time. Depends on sss_pkg and sss_channels.
module sss_serializer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           bit_order,
   input  logic                           load,
   input  sss_pkg::seg_byte_type          load_bytes [sss_pkg::DIGIT_COUNT],
   output sss_pkg::ser_status_type        status,
   sss_rsp_if.source                      rsp_chan
);

   localparam logic [sss_pkg::DIGIT_IDX_W-1:0] LAST_DIGIT =
      sss_pkg::DIGIT_IDX_W'(sss_pkg::DIGIT_COUNT - 1);

   logic                            busy_ff, busy_in;
   logic                            blank_ff, blank_in;
   logic [2:0]                      bit_ff, bit_in;
   logic [sss_pkg::DIGIT_IDX_W-1:0] digit_ff, digit_in;
   sss_pkg::seg_byte_type           bytes_ff [sss_pkg::DIGIT_COUNT];

   logic                  take;
   logic                  final_bit;
   sss_pkg::seg_byte_type cur_byte;
   logic [2:0]            bit_pos;

   assign take      = busy_ff && rsp_chan.ready;
   assign final_bit = blank_ff && (bit_ff == 3'd7) && (digit_ff == LAST_DIGIT);

   always_comb begin
      busy_in  = busy_ff;
      blank_in = blank_ff;
      bit_in   = bit_ff;
      digit_in = digit_ff;
      if (load) begin
         busy_in  = 1'b1;
         blank_in = 1'b0;
         bit_in   = 3'd0;
         digit_in = '0;
      end else if (take) begin
         if (final_bit) begin
            busy_in = 1'b0;
         end else begin
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               blank_in = !blank_ff;
               if (blank_ff) begin
                  digit_in = digit_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         blank_ff <= 1'b0;
         bit_ff   <= 3'd0;
         digit_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         blank_ff <= blank_in;
         bit_ff   <= bit_in;
         digit_ff <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= load_bytes;
      end
   end

   assign cur_byte = blank_ff ? sss_pkg::SEG_BLANK : bytes_ff[digit_ff];
   assign bit_pos  = bit_order ? (3'd7 - bit_ff) : bit_ff;

   assign rsp_chan.valid          = busy_ff;
   assign rsp_chan.digit_enable_n = ~(4'b0001 << digit_ff);
   assign rsp_chan.serial_bit     = cur_byte[bit_pos];
   assign rsp_chan.latch_after    = (bit_ff == 3'd7);
   assign rsp_chan.hold_after     = (bit_ff == 3'd7) && !blank_ff;
   assign rsp_chan.last           = final_bit;

   assign status.busy = busy_ff;
   assign status.done = take && final_bit;

endmodule
